// ----- rtl/core/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg
// Types, character codes and the per-byte decision function of the source
// comment stripper.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [1:0] MODE_CODE  = 2'd0;
	localparam logic [1:0] MODE_LINE  = 2'd1;
	localparam logic [1:0] MODE_BLOCK = 2'd2;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_present;
		logic       run_end;
		logic       text_done;
		logic       open_block_error;
	} result_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       str;
		logic [7:0] prior;
		logic [7:0] sprior;
		logic [1:0] seen;
		logic       seg_ne;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '0;

	typedef struct packed {
		logic [2:0][7:0] b;
		logic            present;
		logic [1:0]      last;
		logic            fin;
		logic            err;
	} job_t;

	typedef struct packed {
		scan_state_t     st;
		logic [2:0][7:0] b;
		logic [1:0]      n;
		logic            two;
	} dec_res_t;

	function automatic scan_state_t scs_remember(scan_state_t s, logic [7:0] c);
		scan_state_t r;
		r        = s;
		r.sprior = s.prior;
		r.prior  = c;
		if (s.seen < 2'd2) begin
			r.seen = s.seen + 2'd1;
		end
		return r;
	endfunction

	function automatic dec_res_t scs_decide(scan_state_t s, logic [7:0] c, logic has_nx,
			logic [7:0] nx);
		dec_res_t r;
		logic     escaped;
		logic     nx_lf;
		r       = '0;
		r.st    = s;
		nx_lf   = has_nx && (nx == CH_LF);
		escaped = (s.seen >= 2'd1) && (s.prior == CH_BSLASH) &&
			!((s.seen >= 2'd2) && (s.sprior == CH_BSLASH));
		if ((s.mode == MODE_CODE) && (c == CH_QUOTE) && !escaped) begin
			r.st.str = ~s.str;
		end
		if (r.st.str) begin
			r.b[0] = c;
			r.n    = 2'd1;
		end else if ((s.mode == MODE_CODE) && (c == CH_SLASH) && has_nx && (nx == CH_SLASH)) begin
			r.st.mode = MODE_LINE;
			r.two     = 1'b1;
		end else if ((s.mode == MODE_CODE) && (c == CH_SLASH) && has_nx && (nx == CH_STAR)) begin
			r.st.mode   = MODE_BLOCK;
			r.st.seg_ne = 1'b1;
			r.two       = 1'b1;
		end else if ((s.mode == MODE_LINE) && (c == CH_CR) && nx_lf) begin
			r.b       = {CH_LF, CH_CR, CH_SPACE};
			r.n       = 2'd3;
			r.st.mode = MODE_CODE;
			r.two     = 1'b1;
		end else if ((s.mode == MODE_LINE) && (c == CH_LF)) begin
			r.b[0]    = CH_SPACE;
			r.b[1]    = CH_LF;
			r.n       = 2'd2;
			r.st.mode = MODE_CODE;
		end else if ((s.mode == MODE_BLOCK) && (c == CH_STAR) && has_nx && (nx == CH_SLASH)) begin
			r.b[0]    = CH_SPACE;
			r.n       = 2'd1;
			r.st.mode = MODE_CODE;
			r.two     = 1'b1;
		end else if ((s.mode == MODE_BLOCK) && (c == CH_CR) && nx_lf) begin
			if (s.seg_ne) begin
				r.b = {CH_LF, CH_CR, CH_SPACE};
				r.n = 2'd3;
			end else begin
				r.b[0] = CH_CR;
				r.b[1] = CH_LF;
				r.n    = 2'd2;
			end
			r.st.seg_ne = 1'b0;
			r.two       = 1'b1;
		end else if ((s.mode == MODE_BLOCK) && (c == CH_LF)) begin
			if (s.seg_ne) begin
				r.b[0] = CH_SPACE;
				r.b[1] = CH_LF;
				r.n    = 2'd2;
			end else begin
				r.b[0] = CH_LF;
				r.n    = 2'd1;
			end
			r.st.seg_ne = 1'b0;
		end else if (s.mode == MODE_CODE) begin
			r.b[0] = c;
			r.n    = 2'd1;
		end else if (s.mode == MODE_BLOCK) begin
			r.st.seg_ne = 1'b1;
		end
		r.st = scs_remember(r.st, c);
		if (r.two) begin
			r.st = scs_remember(r.st, nx);
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/scs_front.sv -----
// ----------------------------------------------------------------------------
// scs_front
// Scanner: holds one byte of lookahead, decides it against the new byte and
// packs the resulting output bytes of one request into a job.
// ----------------------------------------------------------------------------
module scs_front
	import scs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item,
	input  logic  qfull,
	output logic  accept,
	output job_t  job
);

	scan_state_t st_q;
	logic [7:0]  held_q;
	logic        hp_q;

	scan_state_t st_n;
	logic [7:0]  held_n;
	logic        hp_n;

	dec_res_t    d1;
	dec_res_t    d2;
	logic [1:0]  n1;
	logic [1:0]  n2;
	logic [2:0]  total;
	logic [1:0]  cnt;
	logic [1:0]  kk;

	assign accept = push && !qfull;

	always_comb begin
		d1     = scs_decide(st_q, held_q, 1'b1, item.in_byte);
		st_n   = st_q;
		held_n = item.in_byte;
		hp_n   = 1'b1;
		n1     = 2'd0;
		if (hp_q) begin
			st_n = d1.st;
			n1   = d1.n;
			if (d1.two) begin
				hp_n = 1'b0;
			end
		end
		d2 = scs_decide(st_n, held_n, 1'b0, 8'h00);
		n2 = 2'd0;
		if (item.final_byte && hp_n) begin
			n2 = d2.n;
		end
		total = {1'b0, n1} + {1'b0, n2};
		cnt   = (total > 3'd3) ? 2'd3 : total[1:0];
		job   = '0;
		for (int k = 0; k < 3; k++) begin
			kk = 2'(k) - n1;
			if (2'(k) < n1) begin
				job.b[k] = d1.b[k];
			end else begin
				job.b[k] = d2.b[kk];
			end
		end
		if (cnt == 2'd0) begin
			job.b       = '0;
			job.present = 1'b0;
			job.last    = 2'd0;
		end else begin
			job.present = 1'b1;
			job.last    = cnt - 2'd1;
		end
		job.fin = item.final_byte;
		job.err = item.final_byte &&
			(((item.final_byte && hp_n) ? d2.st.mode : st_n.mode) == MODE_BLOCK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SCAN_RESET;
			held_q <= '0;
			hp_q   <= 1'b0;
		end else if (accept) begin
			if (item.final_byte) begin
				st_q   <= SCAN_RESET;
				held_q <= '0;
				hp_q   <= 1'b0;
			end else begin
				st_q   <= st_n;
				held_q <= held_n;
				hp_q   <= hp_n;
			end
		end
	end

endmodule

// ----- rtl/core/scs_queue.sv -----
// ----------------------------------------------------------------------------
// scs_queue
// Short job queue between scanner and output sequencer.
// ----------------------------------------------------------------------------
module scs_queue
	import scs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wdata,
	input  logic rd,
	output job_t head,
	output logic qfull,
	output logic qempty
);

	job_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wp_q;
	logic [QAW-1:0]   rp_q;
	logic [QCW-1:0]   cnt_q;

	assign qfull  = (cnt_q == QCW'(QDEPTH));
	assign qempty = (cnt_q == '0);
	assign head   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == QAW'(QDEPTH - 1)) ? '0 : wp_q + QAW'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == QAW'(QDEPTH - 1)) ? '0 : rp_q + QAW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

endmodule

// ----- rtl/core/scs_back.sv -----
// ----------------------------------------------------------------------------
// scs_back
// Output sequencer: walks the bytes of the head job, one result per pop.
// ----------------------------------------------------------------------------
module scs_back
	import scs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    head,
	input  logic    qempty,
	input  logic    pop,
	output result_t result,
	output logic    deq
);

	logic [1:0] idx_q;
	logic       take;

	assign take = pop && !qempty;
	assign deq  = take && (idx_q == head.last);

	always_comb begin
		result.out_byte         = head.b[idx_q];
		result.byte_present     = head.present;
		result.run_end          = (idx_q == head.last);
		result.text_done        = head.fin;
		result.open_block_error = head.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= deq ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ----- rtl/core/source_comment_stripper_core.sv -----
// ----------------------------------------------------------------------------
// source_comment_stripper_core
// Removes C-style comments from a byte stream: scanner, job queue, sequencer.
// ----------------------------------------------------------------------------
// A request's job is registered in the job queue; its results show at the queue
// head behind any earlier jobs. Throughput: one request per cycle while the queue
// is not full; results leave at one per cycle while pop is high, so a request
// yielding two or three results holds the scanner only once the four-entry job queue fills.
// Reset clears scanner state, lookahead, queue and sequencer at once.
module source_comment_stripper_core
	import scs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic accept;
	job_t job;
	job_t head;
	logic deq;

	scs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.qfull  (full),
		.accept (accept),
		.job    (job)
	);

	scs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wdata  (job),
		.rd     (deq),
		.head   (head),
		.qfull  (full),
		.qempty (empty)
	);

	scs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qempty (empty),
		.pop    (pop),
		.result (result),
		.deq    (deq)
	);

	a_marker_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.byte_present) |-> (result.run_end && result.out_byte == 8'h00))
		else $error("empty marker not a single result");

	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.open_block_error) |-> result.text_done)
		else $error("open block error outside final request");

	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.run_end) |=> (!empty && $stable(result.text_done)))
		else $error("run broken before its last result");

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty))
		else $error("queue full and empty");

endmodule

// ----- sim/strip_checker.sv -----
// ----------------------------------------------------------------------------
// strip_checker
// Watches the request and result queues of the comment stripper, runs its own
// scanner on every accepted request and compares each popped result, field
// by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module strip_checker
	import scs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    full,
	input  item_t   item,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      mismatches,
	output int      pending,
	output int      checked,
	output int      open_texts
);

	logic [1:0] scan_mode;
	logic       in_string;
	logic [7:0] held_char;
	logic       held_valid;
	logic [7:0] last_raw;
	logic [7:0] last_raw2;
	logic [1:0] raw_count;
	logic       segment_busy;
	logic [7:0] emitted[$];
	result_t    cleaned_q[$];

	int mismatch_n = 0;
	int checked_n  = 0;
	int open_n     = 0;
	int pending_n  = 0;

	assign mismatches = mismatch_n;
	assign pending    = pending_n;
	assign checked    = checked_n;
	assign open_texts = open_n;

	task automatic clear_scan();
		scan_mode    = MODE_CODE;
		in_string    = 1'b0;
		held_char    = 8'h00;
		held_valid   = 1'b0;
		last_raw     = 8'h00;
		last_raw2    = 8'h00;
		raw_count    = 2'd0;
		segment_busy = 1'b0;
	endtask

	function automatic void note_raw(logic [7:0] c);
		last_raw2 = last_raw;
		last_raw  = c;
		if (raw_count < 2'd2) begin
			raw_count = raw_count + 2'd1;
		end
	endfunction

	// returns 1 when c and its lookahead were taken as a pair
	function automatic logic decide_char(logic [7:0] c, logic has_nx, logic [7:0] nx);
		logic pair;
		logic lf_next;
		logic escaped;
		pair    = 1'b0;
		lf_next = has_nx && (nx == CH_LF);
		escaped = (raw_count >= 2'd1) && (last_raw == CH_BSLASH) &&
			!((raw_count >= 2'd2) && (last_raw2 == CH_BSLASH));
		if ((scan_mode == MODE_CODE) && (c == CH_QUOTE) && !escaped) begin
			in_string = ~in_string;
		end
		if (in_string) begin
			emitted.push_back(c);
		end else if (scan_mode == MODE_CODE && c == CH_SLASH && has_nx && nx == CH_SLASH) begin
			scan_mode = MODE_LINE;
			pair      = 1'b1;
		end else if (scan_mode == MODE_CODE && c == CH_SLASH && has_nx && nx == CH_STAR) begin
			scan_mode    = MODE_BLOCK;
			segment_busy = 1'b1;
			pair         = 1'b1;
		end else if (scan_mode == MODE_LINE && c == CH_CR && lf_next) begin
			emitted.push_back(CH_SPACE);
			emitted.push_back(CH_CR);
			emitted.push_back(CH_LF);
			scan_mode = MODE_CODE;
			pair      = 1'b1;
		end else if (scan_mode == MODE_LINE && c == CH_LF) begin
			emitted.push_back(CH_SPACE);
			emitted.push_back(CH_LF);
			scan_mode = MODE_CODE;
		end else if (scan_mode == MODE_BLOCK && c == CH_STAR && has_nx && nx == CH_SLASH) begin
			emitted.push_back(CH_SPACE);
			scan_mode = MODE_CODE;
			pair      = 1'b1;
		end else if (scan_mode == MODE_BLOCK && c == CH_CR && lf_next) begin
			if (segment_busy) begin
				emitted.push_back(CH_SPACE);
			end
			emitted.push_back(CH_CR);
			emitted.push_back(CH_LF);
			segment_busy = 1'b0;
			pair         = 1'b1;
		end else if (scan_mode == MODE_BLOCK && c == CH_LF) begin
			if (segment_busy) begin
				emitted.push_back(CH_SPACE);
			end
			emitted.push_back(CH_LF);
			segment_busy = 1'b0;
		end else if (scan_mode == MODE_CODE) begin
			emitted.push_back(c);
		end else if (scan_mode == MODE_BLOCK) begin
			segment_busy = 1'b1;
		end
		note_raw(c);
		if (pair) begin
			note_raw(nx);
		end
		return pair;
	endfunction

	task automatic strip_request(input item_t req);
		logic    open_err;
		int      n;
		result_t r;
		emitted.delete();
		open_err = 1'b0;
		if (held_valid) begin
			if (decide_char(held_char, 1'b1, req.in_byte)) begin
				held_valid = 1'b0;
			end else begin
				held_char = req.in_byte;
			end
		end else begin
			held_char  = req.in_byte;
			held_valid = 1'b1;
		end
		if (req.final_byte) begin
			if (held_valid) begin
				void'(decide_char(held_char, 1'b0, 8'h00));
			end
			held_valid = 1'b0;
			open_err   = (scan_mode == MODE_BLOCK);
			if (open_err) begin
				open_n++;
			end
		end
		n = (emitted.size() > 3) ? 3 : emitted.size();
		r.text_done        = req.final_byte;
		r.open_block_error = open_err;
		if (n == 0) begin
			r.out_byte     = 8'h00;
			r.byte_present = 1'b0;
			r.run_end      = 1'b1;
			cleaned_q.push_back(r);
		end else begin
			for (int k = 0; k < n; k++) begin
				r.out_byte     = emitted[k];
				r.byte_present = 1'b1;
				r.run_end      = (k == n - 1);
				cleaned_q.push_back(r);
			end
		end
		if (req.final_byte) begin
			clear_scan();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		if (!arst_n) begin
			clear_scan();
			cleaned_q.delete();
		end else begin
			if (pop && !empty) begin
				if (cleaned_q.size() == 0) begin
					$error("result with no request pending: out_byte %02h", result.out_byte);
					mismatch_n++;
				end else begin
					want = cleaned_q.pop_front();
					checked_n++;
					if (result.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, actual %02h",
							want.out_byte, result.out_byte);
						mismatch_n++;
					end
					if (result.byte_present !== want.byte_present) begin
						$error("byte_present: expected %0b, actual %0b",
							want.byte_present, result.byte_present);
						mismatch_n++;
					end
					if (result.run_end !== want.run_end) begin
						$error("run_end: expected %0b, actual %0b",
							want.run_end, result.run_end);
						mismatch_n++;
					end
					if (result.text_done !== want.text_done) begin
						$error("text_done: expected %0b, actual %0b",
							want.text_done, result.text_done);
						mismatch_n++;
					end
					if (result.open_block_error !== want.open_block_error) begin
						$error("open_block_error: expected %0b, actual %0b",
							want.open_block_error, result.open_block_error);
						mismatch_n++;
					end
				end
			end
			if (push && !full) begin
				strip_request(item);
			end
		end
		pending_n = cleaned_q.size();
	end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives texts into the comment stripper: a few directed texts for comments,
// strings, escapes and endings, then random texts built from letters,
// comments, strings, escaped quotes and random characters. Requests come in
// bursts, results are popped on varying patterns with one long hold-off, and
// the checker reports mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import scs_pkg::*;

	localparam int CYCLE_LIMIT  = 50000;
	localparam int RANDOM_ITEMS = 180;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;

	int mismatches;
	int pending;
	int checked;
	int open_texts;
	int cycle_count;
	int text_count = 0;

	logic [7:0] text_buf[$];
	item_t      requests[$];

	source_comment_stripper_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	strip_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.open_texts (open_texts)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flush_text();
		item_t it;
		for (int i = 0; i < text_buf.size(); i++) begin
			it.in_byte    = text_buf[i];
			it.final_byte = (i == text_buf.size() - 1);
			requests.push_back(it);
		end
		text_buf.delete();
		text_count++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			text_buf.push_back(s[i]);
		end
		flush_text();
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 11))
			0:       return CH_QUOTE;
			1:       return CH_BSLASH;
			2:       return CH_SLASH;
			3:       return CH_STAR;
			4:       return CH_LF;
			5:       return CH_CR;
			6:       return CH_SPACE;
			7, 8:    return 8'($urandom_range(0, 255));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	task automatic add_fragment();
		int n;
		n = $urandom_range(0, 4);
		case ($urandom_range(0, 9))
			0, 1: begin
				repeat (n + 1) text_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
			end
			2: begin
				text_buf.push_back(CH_SLASH);
				text_buf.push_back(CH_SLASH);
				repeat (n) text_buf.push_back(pick_char());
				if ($urandom_range(0, 1)) begin
					text_buf.push_back(CH_CR);
				end
				text_buf.push_back(CH_LF);
			end
			3: begin
				text_buf.push_back(CH_SLASH);
				text_buf.push_back(CH_STAR);
				repeat (n) begin
					case ($urandom_range(0, 3))
						0: text_buf.push_back(CH_LF);
						1: begin
							text_buf.push_back(CH_CR);
							text_buf.push_back(CH_LF);
						end
						default: text_buf.push_back(pick_char());
					endcase
				end
				text_buf.push_back(CH_STAR);
				text_buf.push_back(CH_SLASH);
			end
			4: begin
				text_buf.push_back(CH_QUOTE);
				repeat (n) begin
					if ($urandom_range(0, 3) == 0) begin
						text_buf.push_back(CH_BSLASH);
					end
					text_buf.push_back(pick_char());
				end
				text_buf.push_back(CH_QUOTE);
			end
			5: begin
				repeat ($urandom_range(1, 2)) text_buf.push_back(CH_BSLASH);
				text_buf.push_back(CH_QUOTE);
			end
			default: text_buf.push_back(pick_char());
		endcase
	endtask

	// receiver: random pops, one long hold-off, then mixed patterns
	initial begin : receiver
		int mode;
		int len;
		int hold;
		int phase;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		repeat (30) begin
			@(posedge clk);
			pop <= 1'($urandom_range(0, 1));
		end
		@(posedge clk);
		pop <= 1'b0;
		for (hold = 0; hold < 40; hold++) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(4, 40);
			for (phase = 0; phase < len; phase++) begin
				@(posedge clk);
				case (mode)
					0:       pop <= 1'b1;
					1:       pop <= 1'($urandom_range(0, 1));
					2:       pop <= ($urandom_range(0, 7) != 0);
					default: pop <= (phase % 3 != 2);
				endcase
			end
		end
	end

	initial begin : watchdog
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
		$error("run did not finish within %0d cycles", CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : sender
		int idx;
		int burst;
		int gap;
		int target;
		int directed_n;
		arst_n = 1'b0;
		push   = 1'b0;
		item   = '0;

		text_buf.push_back(8'h00);
		text_buf.push_back(8'hFF);
		flush_text();
		add_text("\\\"");
		add_text("\"/\\\"\"");
		add_text("//b\015\n");
		add_text("/*a\n\n*/");
		add_text("//z");
		add_text("/*q");
		directed_n = requests.size();

		while (requests.size() < directed_n + RANDOM_ITEMS) begin
			target = $urandom_range(1, 14);
			while (text_buf.size() < target) add_fragment();
			flush_text();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idx = 0;
		while (idx < requests.size()) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst && idx < requests.size(); k++) begin
				push <= 1'b1;
				item <= requests[idx];
				do @(posedge clk); while (full);
				idx++;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		push <= 1'b0;

		// let the checker take in the last request before watching its count
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d bytes in %0d texts, %0d results checked.",
			requests.size(), text_count, checked);
		$display("%0d texts ended inside a block comment.", open_texts);
		if (mismatches == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
